[rtl/tube_chord_length_and_layer_core_assert.svh]
// ----------------------------------------------------------------------------
// tube chord length core assertion macros
// implication checks on the rising clock, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef TUBE_CHORD_LENGTH_AND_LAYER_CORE_ASSERT_SVH
`define TUBE_CHORD_LENGTH_AND_LAYER_CORE_ASSERT_SVH
`ifndef SYNTH
`define TCL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcl assertion failed");
`define TCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcl assertion failed");
`else
`define TCL_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define TCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/tcl_pkg.sv]
// ----------------------------------------------------------------------------
// tcl_pkg
// shared types, constants and layer decode for the tube chord length core
// ----------------------------------------------------------------------------
package tcl_pkg;

    localparam int unsigned QUOT_W = 33;
    localparam int unsigned RAD_CFG_W = 24;
    localparam int unsigned LEN_W = 32;

    localparam logic [7:0] QUARTER_32 = 8'h32;
    localparam logic [7:0] QUARTER_34 = 8'h34;
    localparam logic [7:0] QUARTER_35 = 8'h35;
    localparam logic [7:0] QUARTER_36 = 8'h36;

    typedef struct packed {
        logic       layer_valid;
        logic [2:0] layer;
    } t_layer;

    typedef struct packed {
        logic [2:0]       layer;
        logic             layer_valid;
        logic             pierced;
        logic [LEN_W-1:0] path_length;
    } t_res;

    function automatic t_layer decode_layer(input logic [15:0] det_id);
        t_layer     res;
        logic [3:0] nib;
        nib = det_id[7:4];
        res = '0;
        case (det_id[15:8]) inside
            QUARTER_34, QUARTER_35: begin
                res.layer       = 3'(4'd7 - nib);
                res.layer_valid = 1'b1;
            end
            QUARTER_32, QUARTER_36: begin
                res.layer       = 3'(4'd3 - nib);
                res.layer_valid = 1'b1;
            end
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[rtl/tcl_if.sv]
// ----------------------------------------------------------------------------
// tcl channel interfaces
// hit, result and configuration channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface tcl_hit_if;
    logic               valid;
    logic               ready;
    logic [15:0]        det_id;
    logic signed [31:0] wire_x;
    logic signed [31:0] track_x;
    logic signed [23:0] slope_x;
    logic signed [23:0] slope_y;

    modport source (output valid, det_id, wire_x, track_x, slope_x, slope_y, input ready);
    modport sink (input valid, det_id, wire_x, track_x, slope_x, slope_y, output ready);
endinterface

interface tcl_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  layer;
    logic        layer_valid;
    logic        pierced;
    logic [31:0] path_length;

    modport source (output valid, layer, layer_valid, pierced, path_length, input ready);
    modport sink (input valid, layer, layer_valid, pierced, path_length, output ready);
endinterface

interface tcl_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] tube_radius;

    modport source (output valid, tube_radius, input ready);
    modport sink (input valid, tube_radius, output ready);
endinterface

[rtl/tcl_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// tcl_sqrt_cell
// one digit step of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module tcl_sqrt_cell #(
    parameter int unsigned ROOT_W = 24,
    parameter int unsigned SIDE_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic [SIDE_W-1:0]     i_side,
    output logic [2*ROOT_W-1:0]   o_rad,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    logic [2*ROOT_W-1:0] r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SIDE_W-1:0]   r_side;
    logic [ROOT_W+1:0]   cur;
    logic [ROOT_W+1:0]   trial;
    logic                ge;

    // bring down the next two radicand bits and try root*4+1
    assign cur   = {i_rem[ROOT_W-1:0], i_rad[2*ROOT_W-1 -: 2]};
    assign trial = {i_root, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[2*ROOT_W-3:0], 2'b00};
            r_rem  <= ge ? (cur - trial) : cur;
            r_root <= {i_root[ROOT_W-2:0], ge};
            r_side <= i_side;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

[rtl/tcl_div_cell.sv]
// ----------------------------------------------------------------------------
// tcl_div_cell
// one quotient bit of a restoring divider, registered
// ----------------------------------------------------------------------------
module tcl_div_cell #(
    parameter int unsigned DIV_W  = 24,
    parameter int unsigned SIDE_W = 28
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [DIV_W-1:0]          i_rem,
    input  logic [tcl_pkg::QUOT_W-1:0] i_qn,
    input  logic [DIV_W-1:0]          i_div,
    input  logic [SIDE_W-1:0]         i_side,
    output logic [DIV_W-1:0]          o_rem,
    output logic [tcl_pkg::QUOT_W-1:0] o_qn,
    output logic [DIV_W-1:0]          o_div,
    output logic [SIDE_W-1:0]         o_side
);
    import tcl_pkg::*;

    logic [DIV_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_qn;
    logic [DIV_W-1:0]  r_div;
    logic [SIDE_W-1:0] r_side;
    logic [DIV_W:0]    cur;
    logic [DIV_W:0]    dsub;
    logic              ge;
    logic [DIV_W:0]    diff;

    // dividend bits shift out the top of qn while quotient bits enter below
    assign cur  = {i_rem, i_qn[QUOT_W-1]};
    assign dsub = {1'b0, i_div};
    assign ge   = (cur >= dsub);
    assign diff = ge ? (cur - dsub) : cur;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= diff[DIV_W-1:0];
            r_qn   <= {i_qn[QUOT_W-2:0], ge};
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_qn   = r_qn;
    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

[rtl/tube_chord_length_and_layer_core.sv]
// ----------------------------------------------------------------------------
// tube_chord_length_and_layer_core
// layer decode and track chord length through a drift tube; while not stalled, one hit per cycle
// ----------------------------------------------------------------------------
// The core takes one hit per clock while the output queue has room and returns
// one result word per hit, in order. Between hit accept and the output queue
// lie two input stages, a row of ROOT_W square root cells for sqrt(1+sx^2) and
// sqrt(1+sy^2) side by side, a row of 33 divider cells giving one quotient bit
// each, two stages for r^2 - d^2, another row of ROOT_W square root cells, and
// one multiplier stage. The whole row of cells advances together while the
// two-word output queue has room; the hit channel ready falls only when both
// entries hold words that are not yet taken. The radius register is written
// through the config channel and must only change while no hit is in flight.
module tube_chord_length_and_layer_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcl_hit_if.sink   i_hit,
    tcl_cfg_if.sink   i_cfg,
    tcl_res_if.source o_res
);
    import tcl_pkg::*;

    localparam int unsigned RAD_MIN = (2*FRAC_BITS + 1 > 48) ? 2*FRAC_BITS + 1 : 48;
    localparam int unsigned RAD_W   = 2*((RAD_MIN + 1)/2);
    localparam int unsigned ROOT_W  = RAD_W/2;
    localparam int unsigned DVD_W   = QUOT_W + FRAC_BITS;
    localparam int unsigned LAT     = 2*ROOT_W + 38;
    localparam int unsigned LAY_W   = $bits(t_layer);
    localparam int unsigned DSIDE_W = ROOT_W + LAY_W;
    localparam int unsigned CSIDE_W = 1 + ROOT_W + LAY_W;
    localparam logic [RAD_W-1:0] ONE2 = RAD_W'(1) << (2*FRAC_BITS);

    // control
    logic           [LAT-1:0] r_vld;
    logic           [1:0]     r_cnt;
    logic           [RAD_CFG_W-1:0] r_radius;
    logic                     en;
    logic                     push;
    logic                     pop;

    assign en          = (r_cnt != 2'd2);
    assign i_hit.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_CFG_W'(196608);
        end else if (i_cfg.valid) begin
            r_radius <= i_cfg.tube_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_hit.valid};
        end
    end

    // input stage 0: magnitudes, squares, layer
    logic signed [32:0] dx;
    logic        [32:0] dabs;
    logic        [23:0] ax;
    logic        [23:0] ay;
    logic        [32:0] r_p0_dabs;
    logic        [47:0] r_p0_sqx;
    logic        [47:0] r_p0_sqy;
    t_layer             r_p0_lay;

    assign dx   = {i_hit.track_x[31], i_hit.track_x} - {i_hit.wire_x[31], i_hit.wire_x};
    assign dabs = dx[32] ? 33'(-dx) : 33'(dx);
    assign ax   = i_hit.slope_x[23] ? 24'(-i_hit.slope_x) : 24'(i_hit.slope_x);
    assign ay   = i_hit.slope_y[23] ? 24'(-i_hit.slope_y) : 24'(i_hit.slope_y);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_dabs <= dabs;
            r_p0_sqx  <= ax * ax;
            r_p0_sqy  <= ay * ay;
            r_p0_lay  <= decode_layer(i_hit.det_id);
        end
    end

    // input stage 1: radicands 1 + s^2
    logic [RAD_W-1:0] r_p1_rads;
    logic [RAD_W-1:0] r_p1_radt;
    logic [32:0]      r_p1_dabs;
    t_layer           r_p1_lay;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_rads <= ONE2 + RAD_W'(r_p0_sqx);
            r_p1_radt <= ONE2 + RAD_W'(r_p0_sqy);
            r_p1_dabs <= r_p0_dabs;
            r_p1_lay  <= r_p0_lay;
        end
    end

    // first row of square root cells: s on one side, t on the other
    logic [RAD_W-1:0]  s_rad  [0:ROOT_W];
    logic [ROOT_W+1:0] s_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] s_root [0:ROOT_W];
    logic [32:0]       s_side [0:ROOT_W];
    logic [RAD_W-1:0]  t_rad  [0:ROOT_W];
    logic [ROOT_W+1:0] t_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] t_root [0:ROOT_W];
    logic [LAY_W-1:0]  t_side [0:ROOT_W];

    assign s_rad[0]  = r_p1_rads;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = r_p1_dabs;
    assign t_rad[0]  = r_p1_radt;
    assign t_rem[0]  = '0;
    assign t_root[0] = '0;
    assign t_side[0] = r_p1_lay;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt_st
        tcl_sqrt_cell #(.ROOT_W(ROOT_W), .SIDE_W(33)) u_s (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rad (s_rad[g]),
            .i_rem (s_rem[g]),
            .i_root(s_root[g]),
            .i_side(s_side[g]),
            .o_rad (s_rad[g+1]),
            .o_rem (s_rem[g+1]),
            .o_root(s_root[g+1]),
            .o_side(s_side[g+1])
        );
        tcl_sqrt_cell #(.ROOT_W(ROOT_W), .SIDE_W(LAY_W)) u_t (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rad (t_rad[g]),
            .i_rem (t_rem[g]),
            .i_root(t_root[g]),
            .i_side(t_side[g]),
            .o_rad (t_rad[g+1]),
            .o_rem (t_rem[g+1]),
            .o_root(t_root[g+1]),
            .o_side(t_side[g+1])
        );
    end

    // divider row: d = (dabs << FRAC_BITS) / s
    logic [DVD_W-1:0]   dvd;
    logic [ROOT_W-1:0]  d_rem  [0:QUOT_W];
    logic [QUOT_W-1:0]  d_qn   [0:QUOT_W];
    logic [ROOT_W-1:0]  d_div  [0:QUOT_W];
    logic [DSIDE_W-1:0] d_side [0:QUOT_W];

    assign dvd       = {s_side[ROOT_W], {FRAC_BITS{1'b0}}};
    // top bits of the dividend are below s, so they seed the remainder
    assign d_rem[0]  = ROOT_W'(dvd[DVD_W-1:QUOT_W]);
    assign d_qn[0]   = dvd[QUOT_W-1:0];
    assign d_div[0]  = s_root[ROOT_W];
    assign d_side[0] = {t_root[ROOT_W], t_side[ROOT_W]};

    for (genvar g = 0; g < QUOT_W; g++) begin : g_div
        tcl_div_cell #(.DIV_W(ROOT_W), .SIDE_W(DSIDE_W)) u_d (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (d_rem[g]),
            .i_qn  (d_qn[g]),
            .i_div (d_div[g]),
            .i_side(d_side[g]),
            .o_rem (d_rem[g+1]),
            .o_qn  (d_qn[g+1]),
            .o_div (d_div[g+1]),
            .o_side(d_side[g+1])
        );
    end

    // tube test and squares
    logic [QUOT_W-1:0]    dq;
    logic                 r_m1_pierced;
    logic [47:0]          r_m1_r2;
    logic [47:0]          r_m1_d2;
    logic [DSIDE_W-1:0]   r_m1_side;

    assign dq = d_qn[QUOT_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_pierced <= (dq < QUOT_W'(r_radius));
            r_m1_r2      <= r_radius * r_radius;
            r_m1_d2      <= dq[RAD_CFG_W-1:0] * dq[RAD_CFG_W-1:0];
            r_m1_side    <= d_side[QUOT_W];
        end
    end

    logic [RAD_W-1:0]   r_m2_rad;
    logic [CSIDE_W-1:0] r_m2_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_rad  <= r_m1_pierced ? RAD_W'(r_m1_r2 - r_m1_d2) : '0;
            r_m2_side <= {r_m1_pierced, r_m1_side};
        end
    end

    // second row of square root cells: c = sqrt(r^2 - d^2)
    logic [RAD_W-1:0]   c_rad  [0:ROOT_W];
    logic [ROOT_W+1:0]  c_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]  c_root [0:ROOT_W];
    logic [CSIDE_W-1:0] c_side [0:ROOT_W];

    assign c_rad[0]  = r_m2_rad;
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;
    assign c_side[0] = r_m2_side;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt_c
        tcl_sqrt_cell #(.ROOT_W(ROOT_W), .SIDE_W(CSIDE_W)) u_c (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rad (c_rad[g]),
            .i_rem (c_rem[g]),
            .i_root(c_root[g]),
            .i_side(c_side[g]),
            .o_rad (c_rad[g+1]),
            .o_rem (c_rem[g+1]),
            .o_root(c_root[g+1]),
            .o_side(c_side[g+1])
        );
    end

    // chord times sqrt(1+sy^2)
    logic [CSIDE_W-1:0]  cs;
    logic [2*ROOT_W-1:0] r_m3_prod;
    logic                r_m3_pierced;
    t_layer              r_m3_lay;

    assign cs = c_side[ROOT_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_prod    <= c_root[ROOT_W] * cs[LAY_W +: ROOT_W];
            r_m3_pierced <= cs[CSIDE_W-1];
            r_m3_lay     <= cs[LAY_W-1:0];
        end
    end

    // scale by 2 / 2^FRAC_BITS and saturate
    logic [2*ROOT_W-1:0] wide;
    logic                sat;
    t_res                res_new;

    assign wide = r_m3_prod >> (FRAC_BITS - 1);
    assign sat  = |wide[2*ROOT_W-1:LEN_W];

    always_comb begin
        res_new.layer       = r_m3_lay.layer;
        res_new.layer_valid = r_m3_lay.layer_valid;
        res_new.pierced     = r_m3_pierced;
        if (!r_m3_pierced) begin
            res_new.path_length = '0;
        end else if (sat) begin
            res_new.path_length = '1;
        end else begin
            res_new.path_length = wide[LEN_W-1:0];
        end
    end

    // two-word output queue
    t_res r_q0;
    t_res r_q1;
    t_res n_q0;
    t_res n_q1;
    logic [1:0] n_cnt;

    assign push = en && r_vld[LAT-1];
    assign pop  = o_res.valid && o_res.ready;

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        case ({push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_q0 = res_new;
                end else begin
                    n_q1 = res_new;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_q0  = r_q1;
                n_cnt = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_q0 = res_new;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = res_new;
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_res.valid       = (r_cnt != 2'd0);
    assign o_res.layer       = r_q0.layer;
    assign o_res.layer_valid = r_q0.layer_valid;
    assign o_res.pierced     = r_q0.pierced;
    assign o_res.path_length = r_q0.path_length;

`include "tube_chord_length_and_layer_core_assert.svh"

    `TCL_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `TCL_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, (r_cnt == 2'd2) && !pop, r_cnt == 2'd2)
    `TCL_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_res.valid && !o_res.pierced, o_res.path_length == 32'd0)
    `TCL_ASSERT_SAME(a_bad_layer_zero, i_clk, i_rst_n, o_res.valid && !o_res.layer_valid, o_res.layer == 3'd0)

endmodule
